/* rtl/kvm_pkg.sv */
// kvm_pkg: shared types and codes for the keyed value map engine
// no dependencies
package kvm_pkg;
  localparam logic [1:0] KIND_SET = 2'd0;
  localparam logic [1:0] KIND_ADD = 2'd1;
  localparam logic [1:0] KIND_GET = 2'd2;
  localparam logic [1:0] KIND_RSVD = 2'd3;
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FOUND    = 2'd1;
  localparam logic [1:0] ST_MISSING  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_RADDR = 7'b0000100,
    S_RDATA = 7'b0001000,
    S_EXEC  = 7'b0010000,
    S_TOTAL = 7'b0100000,
    S_CLEAR = 7'b1000000
  } state_t;
endpackage

/* rtl/keyed_value_map_engine_top.sv */
// keyed_value_map_engine_top: hash table with modulo bucket hash, fixed ways per bucket
// depends on kvm_pkg
//
// one operation at a time: start is taken while busy is low, and the result is
// shown for one cycle with out_valid; the receiver cannot stall. after reset the
// block runs a clearing pass over the slot valid memory, one slot a cycle, and
// stays busy until every slot is cleared. an operation runs a restoring divider
// (one quotient bit per cycle) for the bucket index, then forms the bucket base,
// reads the bucket's ways from the slot memory one way a cycle, decides and writes
// back, and updates the 64-bit total, with busy high throughout. the result strobe
// comes in the first idle cycle, so a word held back to back is taken only after
// the previous one has finished. a register write is taken only while idle and no
// start is pending.
module keyed_value_map_engine_top
  import kvm_pkg::*;
#(
  parameter int MAX_BUCKETS = 256,
  parameter int WAYS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic signed [31:0] in_key,
  input  logic [31:0] in_operand,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_entry_value,
  output logic [10:0] out_entry_count,
  output logic [63:0] out_value_total
);
  localparam int SLOTS = MAX_BUCKETS * WAYS;
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int BW = $clog2(MAX_BUCKETS + 1);

  state_t state_r, state_nxt;
  logic [8:0]  bcount_r;
  logic [1:0]  kind_r;
  logic [31:0] key_r, opnd_r;
  logic [31:0] quo_r;          // dividend shifts out of here
  logic [BW:0] rem_r;
  logic [BW-1:0] divisor;
  logic [5:0]  bit_r;
  logic [WW:0] way_r;          // ways issued
  logic [WW:0] rway_r;         // ways received
  logic        rd_v_r;
  logic [AW-1:0] base_r;
  logic        hit_r, free_r;
  logic [AW-1:0] hit_s_r, free_s_r;
  logic [31:0] hit_val_r;
  logic [31:0] mkey [SLOTS];
  logic [31:0] mval [SLOTS];
  logic        mvld [SLOTS];
  logic [31:0] rkey_r, rval_r;
  logic        rvld_r;
  logic [AW-1:0] raddr;
  logic [AW-1:0] rslot_r;
  logic [AW-1:0] clr_r;        // clearing pass slot
  logic [10:0] count_r;
  logic [63:0] total_r;
  logic [63:0] delta_r;        // pending total change

  // effective bucket count, clamped to 1..MAX_BUCKETS
  always_comb begin
    if (bcount_r == 9'd0) divisor = BW'(1);
    else if (32'(bcount_r) > 32'(MAX_BUCKETS)) divisor = BW'(MAX_BUCKETS);
    else divisor = BW'(bcount_r);
  end

  logic [BW:0] rem_sh;
  assign rem_sh = {rem_r[BW-1:0], quo_r[31]};

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = ~busy & ~start;
  assign raddr = AW'(32'(base_r) + 32'(way_r[WW-1:0]));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == AW'(SLOTS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_DIV;
      S_DIV:   if (bit_r == 6'd31) state_nxt = S_RADDR;
      S_RADDR: state_nxt = S_RDATA;
      S_RDATA: if (rway_r == (WW+1)'(WAYS)) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_TOTAL;
      S_TOTAL: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory: read registered, one read and one write port each
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] wr_key, wr_val;
  always_ff @(posedge clk) begin
    rkey_r <= mkey[raddr];
    rval_r <= mval[raddr];
    rvld_r <= mvld[raddr];
    if (wr_en) begin
      mkey[wr_addr] <= wr_key;
      mval[wr_addr] <= wr_val;
    end
    if (state_r == S_CLEAR) mvld[clr_r] <= 1'b0;
    else if (wr_en) mvld[wr_addr] <= 1'b1;
  end

  // decision in the exec cycle
  logic [1:0]  st_c;
  logic [31:0] val_c;
  logic [63:0] d_c;
  logic        ins_c;
  always_comb begin
    wr_en = 1'b0; wr_addr = hit_s_r; wr_key = key_r; wr_val = 32'd0;
    st_c = ST_MISSING; val_c = 32'd0; d_c = 64'd0; ins_c = 1'b0;
    if (kind_r == KIND_SET || kind_r == KIND_ADD) begin
      if (hit_r) begin
        st_c = ST_FOUND; wr_en = (state_r == S_EXEC);
        if (kind_r == KIND_SET) begin
          val_c = opnd_r;
          d_c = {32'd0, opnd_r} - {32'd0, hit_val_r};
        end else begin
          val_c = hit_val_r + opnd_r;
          d_c = {{32{opnd_r[31]}}, opnd_r};
        end
        wr_val = val_c;
      end else if (free_r) begin
        st_c = ST_INSERTED; wr_en = (state_r == S_EXEC); wr_addr = free_s_r;
        val_c = opnd_r; wr_val = opnd_r; d_c = {32'd0, opnd_r}; ins_c = 1'b1;
      end else st_c = ST_FULL;
    end else if (hit_r) begin
      st_c = ST_FOUND; val_c = hit_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; bcount_r <= 9'd256;
      count_r <= '0; total_r <= '0; out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) bcount_r <= cfg_data;
      case (state_r)
        S_CLEAR: clr_r <= clr_r + AW'(1);
        S_IDLE: if (start) begin
          kind_r <= in_kind; key_r <= in_key; opnd_r <= in_operand;
          quo_r <= in_key; rem_r <= '0; bit_r <= '0;
        end
        S_DIV: begin
          // one restoring step
          if (rem_sh >= {1'b0, divisor}) rem_r <= rem_sh - {1'b0, divisor};
          else rem_r <= rem_sh;
          quo_r <= {quo_r[30:0], 1'b0};
          bit_r <= bit_r + 6'd1;
        end
        S_RADDR: begin
          base_r <= AW'(32'(rem_r) * WAYS);
          way_r <= '0; rway_r <= '0; rd_v_r <= 1'b0;
          hit_r <= 1'b0; free_r <= 1'b0;
        end
        S_RDATA: begin
          // issue one way, check the previous one
          if (way_r != (WW+1)'(WAYS)) way_r <= way_r + (WW+1)'(1);
          rd_v_r <= (way_r != (WW+1)'(WAYS));
          rslot_r <= raddr;
          if (rd_v_r) begin
            rway_r <= rway_r + (WW+1)'(1);
            if (rvld_r) begin
              if (!hit_r && rkey_r == key_r) begin
                hit_r <= 1'b1; hit_s_r <= rslot_r; hit_val_r <= rval_r;
              end
            end else if (!free_r) begin
              free_r <= 1'b1; free_s_r <= rslot_r;
            end
          end
        end
        S_EXEC: begin
          if (ins_c) begin
            count_r <= count_r + 11'd1;
          end
          delta_r <= d_c;
          out_status <= st_c; out_entry_value <= val_c;
        end
        S_TOTAL: begin
          total_r <= total_r + delta_r;
          out_value_total <= total_r + delta_r;
          out_entry_count <= count_r;
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // a result strobe follows only the total state
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_TOTAL)) else $error("stray result");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> $past(state_r == S_EXEC))
    else $error("count changed outside exec");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cfg_ready) else $error("cfg ready while busy");
endmodule

/* tb/tb_keyed_value_map_engine_top.sv */
// tb_keyed_value_map_engine_top: self-checking bench for the keyed value map engine
// drives set/add/get words, predicts each result with a shadow hash table
// depends on kvm_pkg and keyed_value_map_engine_top
`timescale 1ns / 1ps

module tb_keyed_value_map_engine_top;
  import kvm_pkg::*;

  localparam int NBUCKETS = 256;
  localparam int NWAYS = 4;
  localparam int NSLOTS = NBUCKETS * NWAYS;
  localparam int RANDOM_WORDS = 1300;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_value;
    logic [10:0] entry_count;
    logic [63:0] value_total;
  } map_reply_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] operand;
    bit          typed;   // reply written in by hand
    map_reply_t  reply;
  } op_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic signed [31:0] in_key;
  logic [31:0] in_operand;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [8:0]  cfg_data;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_entry_value;
  logic [10:0] out_entry_count;
  logic [63:0] out_value_total;

  keyed_value_map_engine_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_key(in_key), .in_operand(in_operand),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_status(out_status), .out_entry_value(out_entry_value),
    .out_entry_count(out_entry_count), .out_value_total(out_value_total)
  );

  // shadow table state
  logic [31:0] shadow_keys [NSLOTS];
  logic [31:0] shadow_vals [NSLOTS];
  bit          shadow_used [NSLOTS];
  logic [10:0] shadow_count;
  logic [63:0] shadow_total;
  logic [8:0]  shadow_buckets;

  map_reply_t  pending_replies[$];
  int          fail_count;
  int          send_idle_pct;
  op_row_t     directed_rows[$];
  logic [31:0] key_pool[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  // apply one operation to the shadow table and return the reply it gives
  function automatic map_reply_t map_apply(logic [1:0] kind, logic [31:0] key,
                                           logic [31:0] operand);
    map_reply_t r;
    int eff;
    int base;
    int hit;
    int free_slot;
    eff = shadow_buckets;
    if (eff == 0) eff = 1;
    if (eff > NBUCKETS) eff = NBUCKETS;
    base = (key % eff) * NWAYS;
    hit = -1;
    free_slot = -1;
    r.entry_value = '0;
    for (int w = 0; w < NWAYS; w++) begin
      if (shadow_used[base + w]) begin
        if (hit < 0 && shadow_keys[base + w] == key) hit = base + w;
      end else if (free_slot < 0) begin
        free_slot = base + w;
      end
    end
    if (kind == KIND_SET || kind == KIND_ADD) begin
      if (hit >= 0) begin
        if (kind == KIND_SET) begin
          shadow_total = shadow_total + {32'd0, operand} - {32'd0, shadow_vals[hit]};
          shadow_vals[hit] = operand;
        end else begin
          shadow_total = shadow_total + {{32{operand[31]}}, operand};
          shadow_vals[hit] = shadow_vals[hit] + operand;
        end
        r.entry_value = shadow_vals[hit];
        r.status = ST_FOUND;
      end else if (free_slot >= 0) begin
        shadow_used[free_slot] = 1'b1;
        shadow_keys[free_slot] = key;
        shadow_vals[free_slot] = operand;
        shadow_total = shadow_total + {32'd0, operand};
        shadow_count = shadow_count + 11'd1;
        r.entry_value = operand;
        r.status = ST_INSERTED;
      end else begin
        r.status = ST_FULL;
      end
    end else begin
      // get and the unused kind behave as a lookup
      if (hit >= 0) begin
        r.entry_value = shadow_vals[hit];
        r.status = ST_FOUND;
      end else begin
        r.status = ST_MISSING;
      end
    end
    r.entry_count = shadow_count;
    r.value_total = shadow_total;
    return r;
  endfunction

  // issue one word; waits for the block to take it, start stays up on return
  task automatic issue_op(logic [1:0] kind, logic [31:0] key, logic [31:0] operand,
                          bit typed, map_reply_t typed_reply);
    map_reply_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_key <= key;
    in_operand <= operand;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = map_apply(kind, key, operand);
    // hand-typed rows must agree with the shadow table too
    if (typed && predicted !== typed_reply) begin
      $display("%0t typed row disagrees: expected %h shadow %h", $time, typed_reply, predicted);
      fail_count++;
    end
    pending_replies.push_back(typed ? typed_reply : predicted);
  endtask

  task automatic drain_replies();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_replies.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    // allow a full operation time before touching the register
    repeat (60) @(posedge clk);
  endtask

  task automatic write_buckets(logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_buckets = value;
  endtask

  // result checker: every strobe pops the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $display("%0t unexpected reply: status %0d value %h", $time, out_status,
                 out_entry_value);
        fail_count++;
      end else begin
        map_reply_t exp_r;
        exp_r = pending_replies.pop_front();
        if (out_status !== exp_r.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time, exp_r.status,
                   out_status);
          fail_count++;
        end
        if (out_entry_value !== exp_r.entry_value) begin
          $display("%0t entry_value mismatch: expected %h actual %h", $time,
                   exp_r.entry_value, out_entry_value);
          fail_count++;
        end
        if (out_entry_count !== exp_r.entry_count) begin
          $display("%0t entry_count mismatch: expected %0d actual %0d", $time,
                   exp_r.entry_count, out_entry_count);
          fail_count++;
        end
        if (out_value_total !== exp_r.value_total) begin
          $display("%0t value_total mismatch: expected %h actual %h", $time,
                   exp_r.value_total, out_value_total);
          fail_count++;
        end
      end
    end
  end

  function automatic op_row_t make_row(logic [1:0] kind, logic [31:0] key,
                                       logic [31:0] operand, bit typed,
                                       logic [1:0] st, logic [31:0] v,
                                       logic [10:0] c, logic [63:0] t);
    op_row_t row;
    row.kind = kind;
    row.key = key;
    row.operand = operand;
    row.typed = typed;
    row.reply = '{status: st, entry_value: v, entry_count: c, value_total: t};
    return row;
  endfunction

  // random key, half the time from a small reused pool so keys hit and buckets fill
  function automatic logic [31:0] pick_key(int span);
    logic [31:0] k;
    case ($urandom_range(3))
      0: k = $urandom;
      1: k = $urandom_range(span);
      default: begin
        if (key_pool.size() == 0) k = $urandom;
        else k = key_pool[$urandom_range(key_pool.size() - 1)];
      end
    endcase
    if (key_pool.size() < 64) key_pool.push_back(k);
    else key_pool[$urandom_range(63)] = k;
    return k;
  endfunction

  initial begin
    logic [8:0] bucket_plan [6];
    logic [1:0] kind;
    logic [31:0] opnd;
    int ops_left;

    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_GET;
    in_key = '0;
    in_operand = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    fail_count = 0;
    send_idle_pct = 0;
    for (int i = 0; i < NSLOTS; i++) begin
      shadow_used[i] = 1'b0;
      shadow_keys[i] = '0;
      shadow_vals[i] = '0;
    end
    shadow_count = '0;
    shadow_total = '0;
    shadow_buckets = 9'd256;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset bucket count 256
    directed_rows.push_back(make_row(KIND_GET, 32'h0000_0000, 32'h0, 1, ST_MISSING, 0, 0, 0));
    directed_rows.push_back(make_row(KIND_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                                     ST_INSERTED, 32'hFFFF_FFFF, 1, 64'hFFFF_FFFF));
    directed_rows.push_back(make_row(KIND_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 1,
                                     ST_FOUND, 32'h0, 1, 64'h1_0000_0000));
    directed_rows.push_back(make_row(KIND_ADD, 32'h8000_0000, 32'h8000_0000, 1,
                                     ST_INSERTED, 32'h8000_0000, 2, 64'h1_8000_0000));
    directed_rows.push_back(make_row(KIND_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(KIND_SET, 32'h8000_0000, 32'h0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(KIND_RSVD, 32'hFFFF_FFFF, 32'h1234_5678, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(KIND_RSVD, 32'h7FFF_FFFF, 32'h0, 0, 0, 0, 0, 0));
    // fill bucket 5 past its ways: the fifth insert reports full
    for (int i = 0; i < 5; i++)
      directed_rows.push_back(make_row(KIND_SET, 32'd5 + 32'd256 * i, 32'h1000 + i, 0,
                                       0, 0, 0, 0));
    directed_rows.push_back(make_row(KIND_ADD, 32'd5 + 32'd256 * 6, 32'h1, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(KIND_GET, 32'd5 + 32'd256 * 4, 32'h0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(KIND_GET, 32'd5 + 32'd256 * 3, 32'h0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(KIND_SET, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(KIND_ADD, 32'h5555_5555, 32'h5555_5555, 0, 0, 0, 0, 0));
    foreach (directed_rows[i])
      issue_op(directed_rows[i].kind, directed_rows[i].key, directed_rows[i].operand,
               directed_rows[i].typed, directed_rows[i].reply);
    drain_replies();

    // bucket count phases: zero acts as one, above-range acts as 256
    bucket_plan = '{9'd0, 9'd1, 9'd7, 9'd511, 9'd256, 9'd300};
    ops_left = RANDOM_WORDS;
    for (int ph = 0; ph < 6; ph++) begin
      write_buckets(bucket_plan[ph]);
      // sender idle pattern: 21%, then 83%, then none
      send_idle_pct = (ph < 2) ? 21 : ((ph < 4) ? 83 : 0);
      for (int n = 0; n < RANDOM_WORDS / 6 && ops_left > 0; n++) begin
        kind = $urandom_range(99) < 4 ? KIND_RSVD : 2'($urandom_range(2));
        opnd = $urandom_range(1) ? $urandom : 32'($urandom_range(15)) - 32'd8;
        issue_op(kind, pick_key(ph == 2 ? 20 : 2000), opnd, 0, '0);
        ops_left--;
      end
      drain_replies();
    end

    if (pending_replies.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/kvm_pkg.sv
rtl/keyed_value_map_engine_top.sv
tb/tb_keyed_value_map_engine_top.sv
